FILE: sv/chh_pkg.sv
// Package: opcode and status codes and fixed field widths of the compacting handle heap.
`timescale 1ns / 1ps
package chh_pkg;

	localparam int OP_W   = 3;
	localparam int ID_W   = 16;
	localparam int SIZE_W = 13;
	localparam int ADDR_W = 12;
	localparam int BYTE_W = 8;
	localparam int ST_W   = 3;

	localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
	localparam logic [OP_W-1:0] OP_RESIZE = 3'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
	localparam logic [OP_W-1:0] OP_FREE   = 3'd3;
	localparam logic [OP_W-1:0] OP_READ   = 3'd4;
	localparam logic [OP_W-1:0] OP_WRITE  = 3'd5;

	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_NO_CHANGE = 3'd1;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [ST_W-1:0] ST_NO_SPACE  = 3'd3;
	localparam logic [ST_W-1:0] ST_ZERO_SIZE = 3'd4;

endpackage

FILE: sv/chh_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module chh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/compacting_handle_heap.sv
// Top level of the compacting handle heap: sequencer, descriptor table and byte arena.
`timescale 1ns / 1ps
// Handle heap that keeps its blocks packed downward from the top of a byte arena. One item is
// taken at a time; in_stall stays high until the sequencer is back in idle, while a finished
// result may still sit in the output register. After reset the block runs a clearing pass that
// zeroes the arena byte by byte before it takes the first item. Unused opcodes, a zero-size
// or table-full alloc and any handle op on an empty heap go straight to the done state; write
// passes through the arena access step, read also through a capture step, and alloc reads the
// last descriptor and then, if the block fits, writes the new one. Resize, lookup and free first
// read the last descriptor, then scan the table one entry at a time. A free or a resize to a
// new size that fits then moves bytes through the arena one at a time, zeroes vacated bytes
// and rewrites the lower descriptors one by one; the arena and descriptor ports set the pace.
module compacting_handle_heap
	import chh_pkg::*;
#(
	parameter int ARENA_BYTES = 4096,
	parameter int MAX_BLOCKS  = 64,
	parameter int DESC_BYTES  = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [OP_W-1:0]   opcode,
	input  logic [ID_W-1:0]   handle,
	input  logic [SIZE_W-1:0] req_size,
	input  logic [ADDR_W-1:0] byte_addr,
	input  logic [BYTE_W-1:0] write_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ST_W-1:0]   status,
	output logic [ID_W-1:0]   handle_out,
	output logic [SIZE_W-1:0] block_offset,
	output logic [BYTE_W-1:0] read_byte
);

	localparam int AW = $clog2(ARENA_BYTES);
	localparam int OW = $clog2(ARENA_BYTES + 1);
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);

	typedef struct packed {
		logic [OW-1:0]   off;
		logic [OW-1:0]   size;
		logic [ID_W-1:0] id;
	} desc_t;

	localparam int DW = $bits(desc_t);

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_RD       = 4'd2;
	localparam logic [3:0] S_RDCAP    = 4'd3;
	localparam logic [3:0] S_LAST_RD  = 4'd4;
	localparam logic [3:0] S_LAST     = 4'd5;
	localparam logic [3:0] S_SCAN_RD  = 4'd6;
	localparam logic [3:0] S_SCAN_CHK = 4'd7;
	localparam logic [3:0] S_ACT      = 4'd8;
	localparam logic [3:0] S_MV_RD    = 4'd9;
	localparam logic [3:0] S_MV_WR    = 4'd10;
	localparam logic [3:0] S_ZERO     = 4'd11;
	localparam logic [3:0] S_DS_RD    = 4'd12;
	localparam logic [3:0] S_DS_WR    = 4'd13;
	localparam logic [3:0] S_DONE     = 4'd14;

	// Control state
	logic [3:0]  state_q;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;

	// Latched item and working registers
	logic [OP_W-1:0]   op_q;
	logic [ID_W-1:0]   h_q;
	logic [SIZE_W-1:0] req_q;
	logic [ADDR_W-1:0] addr_q;
	logic [BYTE_W-1:0] wb_q;
	logic [CW-1:0]     k_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     j_q;
	logic [OW-1:0]     off_q;
	logic [OW-1:0]     old_q;
	logic [OW-1:0]     low_q;
	logic [OW-1:0]     mv_src_q;
	logic [OW-1:0]     mv_len_q;
	logic [OW-1:0]     dlt_q;
	logic              up_q;
	logic [OW-1:0]     z_addr_q;
	logic [OW-1:0]     z_len_q;

	// Result being built and the output register
	logic [ST_W-1:0]   res_st_q;
	logic [ID_W-1:0]   res_h_q;
	logic [OW-1:0]     res_off_q;
	logic [BYTE_W-1:0] res_rb_q;
	logic [ST_W-1:0]   o_st_q;
	logic [ID_W-1:0]   o_h_q;
	logic [OW-1:0]     o_off_q;
	logic [BYTE_W-1:0] o_rb_q;

	// RAM ports
	logic          a_we;
	logic [AW-1:0] a_waddr;
	logic [7:0]    a_wdata;
	logic [AW-1:0] a_raddr;
	logic [7:0]    a_rdata;
	logic          d_we;
	logic [IW-1:0] d_waddr;
	desc_t         d_wdata;
	logic [IW-1:0] d_raddr;
	logic [DW-1:0] d_rdata;

	desc_t       lst;
	logic        accept;
	logic        out_free;
	logic        addr_ok;
	logic [31:0] top32;
	logic [16:0] id17;
	logic [31:0] need_alloc;
	logic        alloc_ok;
	logic [31:0] grow_d32;
	logic        grow_ok;
	logic [OW-1:0] mv_dst;
	logic        is_free;
	logic        is_resize;
	logic [CW-1:0] ds_idx;
	desc_t       ds_entry;

	assign lst        = desc_t'(d_rdata);
	assign accept     = in_valid && (state_q == S_IDLE);
	assign in_stall   = (state_q != S_IDLE);
	assign out_free   = !out_valid_q || !out_stall;
	assign addr_ok    = 32'(addr_q) < 32'(ARENA_BYTES);
	assign is_free    = (op_q == OP_FREE);
	assign is_resize  = (op_q == OP_RESIZE);

	// Alloc fit: size plus DESC_BYTES per block, new one included, must not pass the lowest block
	assign top32      = (cnt_q == '0) ? 32'(ARENA_BYTES) : 32'(lst.off);
	assign id17       = (cnt_q == '0) ? 17'd1 : {1'b0, lst.id} + 17'd1;
	assign need_alloc = 32'(req_q) + 32'(DESC_BYTES) * (32'(cnt_q) + 32'd1);
	assign alloc_ok   = !id17[16] && (need_alloc <= top32);

	// Growth fit: the increase must stay between the descriptor charge and the lowest block
	assign grow_d32   = 32'(req_q) - 32'(old_q);
	assign grow_ok    = (grow_d32 + 32'(DESC_BYTES) * 32'(cnt_q)) <= 32'(low_q);

	assign mv_dst     = up_q ? mv_src_q + dlt_q : mv_src_q - dlt_q;
	assign ds_idx     = is_free ? j_q + CW'(1) : j_q;

	always_comb begin
		ds_entry     = lst;
		ds_entry.off = up_q ? lst.off + dlt_q : lst.off - dlt_q;
		if (is_resize && (j_q == i_q)) begin
			ds_entry.size = OW'(req_q);
		end
	end

	// Drive the two RAM ports from the sequencer state
	always_comb begin
		a_we    = 1'b0;
		a_waddr = AW'(mv_dst);
		a_wdata = a_rdata;
		a_raddr = AW'(mv_src_q);
		d_we    = 1'b0;
		d_waddr = IW'(j_q);
		d_wdata = ds_entry;
		d_raddr = IW'(ds_idx);
		unique case (state_q)
			S_CLEAR: begin
				a_we    = 1'b1;
				a_waddr = clr_q;
				a_wdata = '0;
			end
			S_RD: begin
				a_raddr = AW'(addr_q);
				a_we    = (op_q == OP_WRITE) && addr_ok;
				a_waddr = AW'(addr_q);
				a_wdata = wb_q;
			end
			S_MV_WR: begin
				a_we = 1'b1;
			end
			S_ZERO: begin
				a_we    = (z_len_q != '0);
				a_waddr = AW'(z_addr_q);
				a_wdata = '0;
			end
			S_LAST_RD: begin
				d_raddr = IW'(cnt_q - CW'(1));
			end
			S_LAST: begin
				d_we         = (op_q == OP_ALLOC) && alloc_ok;
				d_waddr      = IW'(cnt_q);
				d_wdata.off  = OW'(top32 - 32'(req_q));
				d_wdata.size = OW'(req_q);
				d_wdata.id   = id17[ID_W-1:0];
			end
			S_SCAN_RD: begin
				d_raddr = IW'(k_q);
			end
			S_DS_WR: begin
				d_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	chh_ram #(.WIDTH(8), .DEPTH(ARENA_BYTES)) u_arena (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	chh_ram #(.WIDTH(DW), .DEPTH(MAX_BLOCKS)) u_desc (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Drop the shown result once taken, unless a new one replaces it now
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					// Zero the arena once, a byte per cycle
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(ARENA_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q      <= opcode;
						h_q       <= handle;
						req_q     <= req_size;
						addr_q    <= byte_addr;
						wb_q      <= write_byte;
						res_st_q  <= ST_OK;
						res_h_q   <= '0;
						res_off_q <= '0;
						res_rb_q  <= '0;
						k_q       <= '0;
						priority if (opcode == OP_ALLOC) begin
							priority if (req_size == '0) begin
								res_st_q <= ST_ZERO_SIZE;
								state_q  <= S_DONE;
							end else if (32'(cnt_q) >= 32'(MAX_BLOCKS)) begin
								res_st_q <= ST_NO_SPACE;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_LAST_RD;
							end
						end else if (opcode == OP_RESIZE || opcode == OP_LOOKUP ||
								opcode == OP_FREE) begin
							if (cnt_q == '0) begin
								res_st_q <= ST_NOT_FOUND;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_LAST_RD;
							end
						end else if (opcode == OP_READ || opcode == OP_WRITE) begin
							state_q <= S_RD;
						end else begin
							res_st_q <= ST_NO_CHANGE;
							state_q  <= S_DONE;
						end
					end
				end
				S_RD: begin
					state_q <= (op_q == OP_READ) ? S_RDCAP : S_DONE;
				end
				S_RDCAP: begin
					if (addr_ok) begin
						res_rb_q <= a_rdata;
					end
					state_q <= S_DONE;
				end
				S_LAST_RD: begin
					state_q <= S_LAST;
				end
				S_LAST: begin
					if (op_q == OP_ALLOC) begin
						if (alloc_ok) begin
							cnt_q   <= cnt_q + CW'(1);
							res_h_q <= id17[ID_W-1:0];
						end else begin
							res_st_q <= ST_NO_SPACE;
						end
						state_q <= S_DONE;
					end else begin
						// Hold the lowest block offset, then search from the first entry
						low_q   <= lst.off;
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					priority if (lst.id == h_q) begin
						i_q     <= k_q;
						j_q     <= k_q;
						off_q   <= lst.off;
						old_q   <= lst.size;
						state_q <= S_ACT;
					end else if (k_q + CW'(1) == cnt_q) begin
						res_st_q <= ST_NOT_FOUND;
						state_q  <= S_DONE;
					end else begin
						k_q     <= k_q + CW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_ACT: begin
					z_addr_q <= low_q;
					z_len_q  <= '0;
					priority if (op_q == OP_LOOKUP) begin
						res_off_q <= off_q;
						state_q   <= S_DONE;
					end else if (op_q == OP_FREE) begin
						// Move lower blocks up by the freed size, top byte first
						up_q     <= 1'b1;
						dlt_q    <= old_q;
						mv_src_q <= off_q - OW'(1);
						mv_len_q <= off_q - low_q;
						z_len_q  <= old_q;
						state_q  <= S_MV_RD;
					end else if (32'(req_q) == 32'(old_q)) begin
						res_st_q <= ST_NO_CHANGE;
						state_q  <= S_DONE;
					end else if (32'(req_q) < 32'(old_q)) begin
						up_q     <= 1'b1;
						dlt_q    <= old_q - OW'(req_q);
						mv_src_q <= off_q + OW'(req_q) - OW'(1);
						mv_len_q <= off_q + OW'(req_q) - low_q;
						z_len_q  <= old_q - OW'(req_q);
						state_q  <= S_MV_RD;
					end else if (!grow_ok) begin
						res_st_q <= ST_NO_SPACE;
						state_q  <= S_DONE;
					end else begin
						// Grow: move down, bottom byte first
						up_q     <= 1'b0;
						dlt_q    <= OW'(grow_d32);
						mv_src_q <= low_q;
						mv_len_q <= off_q + old_q - low_q;
						state_q  <= S_MV_RD;
					end
				end
				S_MV_RD: begin
					state_q <= (mv_len_q == '0) ? S_ZERO : S_MV_WR;
				end
				S_MV_WR: begin
					mv_len_q <= mv_len_q - OW'(1);
					mv_src_q <= up_q ? mv_src_q - OW'(1) : mv_src_q + OW'(1);
					state_q  <= S_MV_RD;
				end
				S_ZERO: begin
					if (z_len_q == '0) begin
						state_q <= S_DS_RD;
					end else begin
						z_addr_q <= z_addr_q + OW'(1);
						z_len_q  <= z_len_q - OW'(1);
					end
				end
				S_DS_RD: begin
					if (ds_idx >= cnt_q) begin
						if (is_free) begin
							cnt_q <= cnt_q - CW'(1);
						end
						state_q <= S_DONE;
					end else begin
						state_q <= S_DS_WR;
					end
				end
				S_DS_WR: begin
					j_q     <= j_q + CW'(1);
					state_q <= S_DS_RD;
				end
				S_DONE: begin
					// Wait for the output register to drain
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			o_st_q  <= res_st_q;
			o_h_q   <= res_h_q;
			o_off_q <= res_off_q;
			o_rb_q  <= res_rb_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = o_st_q;
	assign handle_out   = o_h_q;
	assign block_offset = SIZE_W'(o_off_q);
	assign read_byte    = o_rb_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(MAX_BLOCKS))
		else $error("block count above table depth");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |->
		(cnt_q == $past(cnt_q) + CW'(1) || cnt_q == $past(cnt_q) - CW'(1)))
		else $error("block count moved by more than one");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result shown without finishing an item");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (in_stall && !out_valid_q))
		else $error("item traffic during clearing pass");

endmodule

FILE: tb/sv/testbench.sv
// Testbench for the compacting handle heap: queued driver, clocked monitor and a behavioural predictor.
`timescale 1ns / 1ps
module testbench;
	import chh_pkg::*;

	localparam int ARENA = 4096;
	localparam int SLOTS = 64;
	localparam int DESC  = 12;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ID_W-1:0]   hnd;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} heap_req_t;

	typedef struct packed {
		logic [ST_W-1:0]   st;
		logic [ID_W-1:0]   hout;
		logic [SIZE_W-1:0] boff;
		logic [BYTE_W-1:0] rbyte;
	} heap_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OP_W-1:0] opcode = '0;
	logic [ID_W-1:0] handle = '0;
	logic [SIZE_W-1:0] req_size = '0;
	logic [ADDR_W-1:0] byte_addr = '0;
	logic [BYTE_W-1:0] write_byte = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic [ST_W-1:0] status;
	logic [ID_W-1:0] handle_out;
	logic [SIZE_W-1:0] block_offset;
	logic [BYTE_W-1:0] read_byte;

	compacting_handle_heap DUT (.*);

	always #5 clk = ~clk;

	// Predictor's own copy of the heap
	int unsigned blk_off [SLOTS];
	int unsigned blk_len [SLOTS];
	int unsigned blk_id  [SLOTS];
	int unsigned live_blocks = 0;
	logic [7:0]  heap_mem [ARENA];

	heap_req_t pending_reqs[$];
	heap_rsp_t expected_rsps[$];
	int errors = 0;
	bit stim_done = 1'b0;
	bit hold_rx = 1'b0;    // long receiver hold-off requested
	bit drain_req = 1'b0;  // sender pauses until everything has come back

	// Walk the heap forward by one item and return its outcome
	function automatic heap_rsp_t heap_apply(heap_req_t r);
		heap_rsp_t o;
		int f;
		int unsigned low, off, old, d, n, top, id;
		longint room;
		o = '0;
		o.st = ST_OK;
		case (r.op)
			OP_ALLOC: begin
				if (r.size == 0) o.st = ST_ZERO_SIZE;
				else if (live_blocks >= SLOTS) o.st = ST_NO_SPACE;
				else begin
					top = live_blocks ? blk_off[live_blocks-1] : ARENA;
					id = live_blocks ? blk_id[live_blocks-1] + 1 : 1;
					room = longint'(top) - DESC * (live_blocks + 1);
					if (id > 65535 || longint'(r.size) > room) o.st = ST_NO_SPACE;
					else begin
						blk_off[live_blocks] = top - r.size;
						blk_len[live_blocks] = r.size;
						blk_id[live_blocks] = id;
						live_blocks++;
						o.hout = ID_W'(id);
					end
				end
			end
			OP_RESIZE, OP_LOOKUP, OP_FREE: begin
				f = -1;
				for (int k = 0; k < live_blocks; k++)
					if (f < 0 && blk_id[k] == r.hnd) f = k;
				if (f < 0) o.st = ST_NOT_FOUND;
				else begin
					low = blk_off[live_blocks-1];
					off = blk_off[f];
					old = blk_len[f];
					if (r.op == OP_LOOKUP) o.boff = SIZE_W'(off);
					else if (r.op == OP_RESIZE) begin
						if (r.size == old) o.st = ST_NO_CHANGE;
						else if (r.size < old) begin
							d = old - r.size;
							n = off + r.size - low;
							// move up: copy from the top end down
							for (int k = n - 1; k >= 0; k--) heap_mem[low+d+k] = heap_mem[low+k];
							for (int k = 0; k < d; k++) heap_mem[low+k] = 8'h00;
							for (int j = f; j < live_blocks; j++) blk_off[j] += d;
							blk_len[f] = r.size;
						end else begin
							d = r.size - old;
							room = longint'(low) - DESC * live_blocks;
							if (longint'(d) > room) o.st = ST_NO_SPACE;
							else begin
								n = off + old - low;
								for (int k = 0; k < n; k++) heap_mem[low-d+k] = heap_mem[low+k];
								for (int j = f; j < live_blocks; j++) blk_off[j] -= d;
								blk_len[f] = r.size;
							end
						end
					end else begin
						n = off - low;
						for (int k = n - 1; k >= 0; k--) heap_mem[low+old+k] = heap_mem[low+k];
						for (int k = 0; k < old; k++) heap_mem[low+k] = 8'h00;
						for (int j = f; j + 1 < live_blocks; j++) begin
							blk_off[j] = blk_off[j+1] + old;
							blk_len[j] = blk_len[j+1];
							blk_id[j] = blk_id[j+1];
						end
						live_blocks--;
					end
				end
			end
			OP_READ: o.rbyte = heap_mem[r.addr];
			OP_WRITE: heap_mem[r.addr] = r.data;
			default: o.st = ST_NO_CHANGE;
		endcase
		return o;
	endfunction

	function automatic heap_req_t mk_req(logic [OP_W-1:0] op, int h, int sz, int a, int b);
		heap_req_t r;
		r.op = op;
		r.hnd = ID_W'(h);
		r.size = SIZE_W'(sz);
		r.addr = ADDR_W'(a);
		r.data = BYTE_W'(b);
		return r;
	endfunction

	// Pick a handle that is mostly live, sometimes stale or zero
	function automatic int pick_handle();
		int unsigned p;
		p = $urandom_range(0, 9);
		if (live_blocks > 0 && p < 8) return blk_id[$urandom_range(0, live_blocks - 1)];
		if (p == 8) return 0;
		return $urandom_range(0, 65535);
	endfunction

	// Mostly small sizes; now and then a big one or an edge value
	function automatic int pick_size();
		case ($urandom_range(0, 19))
			0: return 0;
			1: return $urandom_range(0, 8191);
			2: return 4096;
			3: return $urandom_range(256, 2048);
			default: return $urandom_range(1, 96);
		endcase
	endfunction

	function automatic heap_req_t rand_req();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 25) return mk_req(OP_ALLOC, $urandom, pick_size(), $urandom, $urandom);
		if (p < 40) return mk_req(OP_RESIZE, pick_handle(), pick_size(), $urandom, $urandom);
		if (p < 50) return mk_req(OP_LOOKUP, pick_handle(), $urandom, $urandom, $urandom);
		if (p < 62) return mk_req(OP_FREE, pick_handle(), $urandom, $urandom, $urandom);
		if (p < 78) return mk_req(OP_READ, $urandom, $urandom,
			(p < 72) ? $urandom_range(3500, 4095) : $urandom_range(0, 4095), $urandom);
		if (p < 96) return mk_req(OP_WRITE, $urandom, $urandom,
			(p < 90) ? $urandom_range(3500, 4095) : $urandom_range(0, 4095), $urandom);
		return mk_req(OP_W'($urandom_range(6, 7)), $urandom, $urandom, $urandom, $urandom);
	endfunction

	// Fill the pending queue; predictions are made at acceptance time
	initial begin
		for (int k = 0; k < ARENA; k++) heap_mem[k] = 8'h00;
		// directed opening
		pending_reqs.push_back(mk_req(OP_LOOKUP, 0, 0, 0, 0));
		pending_reqs.push_back(mk_req(OP_FREE, 16'hFFFF, 0, 0, 0));
		pending_reqs.push_back(mk_req(OP_ALLOC, 0, 0, 0, 0));
		pending_reqs.push_back(mk_req(OP_ALLOC, 0, 8191, 0, 0));
		pending_reqs.push_back(mk_req(OP_ALLOC, 0, 4096, 0, 0));
		pending_reqs.push_back(mk_req(OP_ALLOC, 0, 4084, 0, 0));
		pending_reqs.push_back(mk_req(OP_FREE, 1, 0, 0, 0));
		pending_reqs.push_back(mk_req(OP_ALLOC, 0, 16, 0, 0));
		pending_reqs.push_back(mk_req(OP_ALLOC, 0, 8, 0, 0));
		pending_reqs.push_back(mk_req(OP_WRITE, 0, 0, 4095, 8'hFF));
		pending_reqs.push_back(mk_req(OP_WRITE, 0, 0, 4072, 8'hA5));
		pending_reqs.push_back(mk_req(OP_READ, 0, 0, 4095, 0));
		pending_reqs.push_back(mk_req(OP_LOOKUP, 2, 0, 0, 0));
		pending_reqs.push_back(mk_req(OP_RESIZE, 2, 16, 0, 0));
		pending_reqs.push_back(mk_req(OP_RESIZE, 2, 4, 0, 0));
		pending_reqs.push_back(mk_req(OP_RESIZE, 2, 40, 0, 0));
		pending_reqs.push_back(mk_req(OP_RESIZE, 3, 0, 0, 0));
		pending_reqs.push_back(mk_req(OP_RESIZE, 3, 8191, 0, 0));
		pending_reqs.push_back(mk_req(OP_READ, 0, 0, 4072, 0));
		pending_reqs.push_back(mk_req(OP_READ, 0, 0, 0, 0));
		pending_reqs.push_back(mk_req(3'd6, 16'hFFFF, 8191, 4095, 255));
		pending_reqs.push_back(mk_req(3'd7, 0, 0, 0, 0));
		pending_reqs.push_back(mk_req(OP_FREE, 2, 0, 0, 0));
		pending_reqs.push_back(mk_req(OP_FREE, 2, 0, 0, 0));
		// random part; placeholders, each drawn against the predicted heap when issued
		for (int k = 0; k < 116; k++) pending_reqs.push_back(mk_req(0, 0, 0, 0, 0));
	end

	// Sender: hold valid, draw a gap per item, refine random items at issue
	int tx_gap = 0;
	int tx_sent = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_rsps.push_back(heap_apply({opcode, handle, req_size, byte_addr, write_byte}));
				tx_sent <= tx_sent + 1;
				tx_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
			end
			if (!(in_valid && in_stall)) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (drain_req && expected_rsps.size() != 0) begin
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					heap_req_t r;
					r = pending_reqs.pop_front();
					if (tx_sent + (in_valid && !in_stall) >= 24) r = rand_req();
					{opcode, handle, req_size, byte_addr, write_byte} <= r;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
					stim_done = 1'b1;
				end
			end
		end
	end

	// Receiver: random stall per item, plus one long hold-off
	int rx_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				heap_rsp_t e;
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected result st=%0d", $time, status);
					errors++;
				end else begin
					e = expected_rsps.pop_front();
					if (status !== e.st)
						$display("%0t: status exp %0d got %0d", $time, e.st, status);
					if (handle_out !== e.hout)
						$display("%0t: handle_out exp %0d got %0d", $time, e.hout, handle_out);
					if (block_offset !== e.boff)
						$display("%0t: block_offset exp %0d got %0d", $time, e.boff, block_offset);
					if (read_byte !== e.rbyte)
						$display("%0t: read_byte exp %0d got %0d", $time, e.rbyte, read_byte);
					if (status !== e.st || handle_out !== e.hout ||
						block_offset !== e.boff || read_byte !== e.rbyte) errors++;
				end
				rx_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 13);
			end
			if (hold_rx) out_stall <= 1'b1;
			else if (rx_gap > 0) begin
				rx_gap--;
				out_stall <= 1'b1;
			end else out_stall <= 1'b0;
		end
	end

	// Phase control: one long receiver hold-off, one sender drain pause
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (tx_sent >= 40);
		hold_rx = 1'b1;
		repeat (3000) @(posedge clk);
		hold_rx = 1'b0;
		wait (tx_sent >= 90);
		drain_req = 1'b1;
		wait (expected_rsps.size() == 0);
		repeat (20) @(posedge clk);
		drain_req = 1'b0;
		wait (stim_done && !in_valid && expected_rsps.size() == 0);
		repeat (20000) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	initial begin
		#400ms;
		$display("status: fail");
		$finish;
	end

endmodule
